// ===== hw/rtl/mrot_pkg.sv =====
// Shared widths, the side reset value, transaction opcodes and the controller-to-datapath command type.
package mrot_pkg;

	// Width of the side length register
	localparam int SIDE_W = 6;
	// Width of one matrix element
	localparam int VALUE_W = 32;
	// Side length after reset
	localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

	// Opcodes of an input transaction
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr;   // store the incoming element
		logic rd;   // read one rotated element
		logic clr;  // return zero for an early fetch
	} dp_cmd_t;

endpackage

// ===== hw/rtl/mrot_dp.sv =====
// Element buffer and result register of the rotation block.
module mrot_dp #(
	parameter int IDX_W = 5
) (
	input  logic                          clk,
	input  mrot_pkg::dp_cmd_t             cmd,
	input  logic [2*IDX_W-1:0]            wr_addr,
	input  logic [2*IDX_W-1:0]            rd_addr,
	input  logic [mrot_pkg::VALUE_W-1:0]  element_value,
	output logic [mrot_pkg::VALUE_W-1:0]  rotated_value
);
	import mrot_pkg::*;

	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH = 1 << ADDR_W;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] value_q;

	// Write the loaded element at its row and column
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= element_value;
		end
	end

	// Read the rotated element, or give zero on an early fetch
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			value_q <= mem[rd_addr];
		end else if (cmd.clr) begin
			value_q <= '0;
		end
	end

	assign rotated_value = value_q;

endmodule

// ===== hw/rtl/mrot_ctrl.sv =====
// Controller: fill state, load and fetch positions, addresses and result flags.
module mrot_ctrl #(
	parameter int MAX_SIDE = 32,
	parameter int IDX_W = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mrot_pkg::SIDE_W-1:0]   cfg_wdata,
	input  logic                          start,
	input  logic                          opcode,
	output logic                          busy,
	output mrot_pkg::dp_cmd_t             cmd,
	output logic [2*IDX_W-1:0]            wr_addr,
	output logic [2*IDX_W-1:0]            rd_addr,
	output logic                          done,
	output logic                          last,
	output logic                          not_ready
);
	import mrot_pkg::*;

	// Fill state: still loading, or a complete matrix is held
	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_FULL = 1'b1;

	logic              state_q, state_d;
	logic [SIDE_W-1:0] side_q;
	logic [IDX_W-1:0]  nm1;
	logic [IDX_W-1:0]  load_row_q, load_col_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [IDX_W-1:0]  wr_row, wr_col;
	logic [IDX_W-1:0]  src_row;
	logic              accept, do_load, do_fetch, full;
	logic              load_end, fetch_end;
	logic              done_q, last_q, not_ready_q;

	// Clamp the side length to 1..MAX_SIDE and keep the last index
	always_comb begin
		if (side_q == '0) begin
			nm1 = '0;
		end else if (int'(side_q) > MAX_SIDE) begin
			nm1 = IDX_W'(MAX_SIDE - 1);
		end else begin
			nm1 = IDX_W'(side_q - 1'b1);
		end
	end

	// Decode the transaction; a side write drops any start in the same cycle
	assign busy     = 1'b0;
	assign accept   = start & ~busy & ~cfg_we;
	assign do_load  = accept & (opcode == OP_LOAD);
	assign do_fetch = accept & (opcode == OP_FETCH);
	assign full     = (state_q == ST_FULL);

	// A load after a complete matrix restarts at the origin
	assign wr_row   = full ? '0 : load_row_q;
	assign wr_col   = full ? '0 : load_col_q;
	assign load_end = (wr_row == nm1) && (wr_col == nm1);

	// Rotated source: out(r,c) = in(N-1-c, r)
	assign src_row   = nm1 - out_col_q;
	assign fetch_end = (out_row_q == nm1) && (out_col_q == nm1);

	assign wr_addr = {wr_row, wr_col};
	assign rd_addr = {src_row, out_row_q};

	assign cmd.wr  = do_load;
	assign cmd.rd  = do_fetch & full;
	assign cmd.clr = do_fetch & ~full;

	// Next fill state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (do_load && load_end) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				if (do_load && !load_end) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
		if (cfg_we) begin
			state_d = ST_LOAD;
		end
	end

	// Hold the side length and the fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SIDE_RESET;
			state_q <= ST_LOAD;
		end else begin
			if (cfg_we) begin
				side_q <= cfg_wdata;
			end
			state_q <= state_d;
		end
	end

	// Advance the load position in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (cfg_we) begin
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (do_load) begin
			if (wr_col == nm1) begin
				load_col_q <= '0;
				load_row_q <= (wr_row == nm1) ? '0 : wr_row + 1'b1;
			end else begin
				load_col_q <= wr_col + 1'b1;
				load_row_q <= wr_row;
			end
		end
	end

	// Advance the fetch position; wrap after the last element, restart on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we || do_load) begin
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (do_fetch && full) begin
			if (out_col_q == nm1) begin
				out_col_q <= '0;
				out_row_q <= (out_row_q == nm1) ? '0 : out_row_q + 1'b1;
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	// Register the result strobe and flags alongside the buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			last_q      <= 1'b0;
			not_ready_q <= 1'b0;
		end else begin
			done_q      <= do_fetch;
			last_q      <= do_fetch & full & fetch_end;
			not_ready_q <= do_fetch & ~full;
		end
	end

	assign done      = done_q;
	assign last      = last_q;
	assign not_ready = not_ready_q;

endmodule

// ===== hw/rtl/matrix_rotate_90.sv =====
// Top level of the 90-degree clockwise matrix rotation block.
//
//  channel    ports                                   handshake
//  --------   -------------------------------------   ---------------------------
//  config     cfg_we, cfg_wdata                       write when cfg_we is high
//  input      start, busy, opcode, element_value      taken when start & !busy & !cfg_we
//  result     done, rotated_value, last, not_ready    valid for the done cycle
//
// One transaction per cycle; busy is never raised. A fetch gives its result
// in the cycle after it is taken, set by the registered read of the element buffer.
// A load gives no result. Reset clears positions and fill state; the buffer
// itself is not cleared, as only written entries are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module matrix_rotate_90 #(
	parameter int MAX_SIDE = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mrot_pkg::SIDE_W-1:0]   cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [mrot_pkg::VALUE_W-1:0]  element_value,
	output logic                          done,
	output logic [mrot_pkg::VALUE_W-1:0]  rotated_value,
	output logic                          last,
	output logic                          not_ready
);
	import mrot_pkg::*;

	localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	dp_cmd_t            cmd;
	logic [2*IDX_W-1:0] wr_addr;
	logic [2*IDX_W-1:0] rd_addr;

	mrot_ctrl #(
		.MAX_SIDE (MAX_SIDE),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.opcode    (opcode),
		.busy      (busy),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.done      (done),
		.last      (last),
		.not_ready (not_ready)
	);

	mrot_dp #(
		.IDX_W (IDX_W)
	) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr       (rd_addr),
		.element_value (element_value),
		.rotated_value (rotated_value)
	);

endmodule

// ===== hw/rtl/mrot_checker.sv =====
// Port-level checks of the rotation block, bound to the top level.
module mrot_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic                          start,
	input logic                          busy,
	input logic                          opcode,
	input logic                          done,
	input logic [mrot_pkg::VALUE_W-1:0]  rotated_value,
	input logic                          last,
	input logic                          not_ready
);
	import mrot_pkg::*;

	// An early fetch returns zero and is never the last element
	assert property (@(posedge clk) disable iff (!arst_n)
		done && not_ready |-> rotated_value == '0 && !last)
		else $error("early fetch result carries data or last");

	// Every result comes from a fetch taken in the previous cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && opcode == OP_FETCH && !cfg_we))
		else $error("result without a fetch transaction");

	// Every fetch taken gives a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_FETCH && !cfg_we |=> done)
		else $error("fetch transaction gave no result");

	// A load gives no result
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_LOAD |=> !done)
		else $error("load transaction gave a result");

	// A fetch straight after a side write finds no matrix
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_we) && !cfg_we && start && !busy && opcode == OP_FETCH
		|=> done && not_ready)
		else $error("fetch after side write did not report not ready");

endmodule

bind matrix_rotate_90 mrot_checker u_mrot_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.start         (start),
	.busy          (busy),
	.opcode        (opcode),
	.done          (done),
	.rotated_value (rotated_value),
	.last          (last),
	.not_ready     (not_ready)
);

// ===== dv/tb_matrix_rotate_90.sv =====
// Self-checking testbench for the 90-degree clockwise matrix rotation block.
module tb_matrix_rotate_90;

	import mrot_pkg::*;

	localparam int MAX_SIDE = 32;
	localparam int RANDOM_ITEMS = 1350;

	// One rotated element as it leaves the block
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               not_ready;
	} rot_result_t;

	// Rows of the directed plan
	typedef enum {ROW_CFG, ROW_LOAD, ROW_FETCH} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [VALUE_W-1:0] data;
		bit                 typed;
		rot_result_t        res;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [SIDE_W-1:0]  cfg_wdata;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [VALUE_W-1:0] element_value;
	logic               done;
	logic [VALUE_W-1:0] rotated_value;
	logic               last;
	logic               not_ready;

	// Sideband that travels with each transaction: a hand-typed expectation
	logic        tag_typed;
	rot_result_t tag_res;

	// Mirror of the block state
	logic [VALUE_W-1:0] mirror [MAX_SIDE*MAX_SIDE];
	int unsigned side_reg = SIDE_RESET;
	int unsigned ld_row = 0;
	int unsigned ld_col = 0;
	int unsigned rd_row = 0;
	int unsigned rd_col = 0;
	bit          held_full = 1'b0;

	rot_result_t due_elements [$];
	int          fault_count = 0;
	int          items_sent = 0;
	bit          no_idle = 1'b0;
	plan_row_t   plan [26];

	matrix_rotate_90 #(
		.MAX_SIDE(MAX_SIDE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.element_value(element_value),
		.done         (done),
		.rotated_value(rotated_value),
		.last         (last),
		.not_ready    (not_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamp the register to the side actually in use
	function automatic int unsigned side_in_use();
		if (side_reg == 0)
			return 1;
		if (side_reg > MAX_SIDE)
			return MAX_SIDE;
		return side_reg;
	endfunction

	function automatic void drop_matrix();
		ld_row = 0;
		ld_col = 0;
		rd_row = 0;
		rd_col = 0;
		held_full = 1'b0;
	endfunction

	// Advance the mirror by one transaction; returns 1 when a result is due
	function automatic bit rotate_step(input logic op, input logic [VALUE_W-1:0] val,
			output rot_result_t res);
		int unsigned n;
		n = side_in_use();
		res = '0;
		if (op == OP_LOAD) begin
			if (held_full)
				drop_matrix();
			if (ld_row >= n || ld_col >= n) begin
				ld_row = 0;
				ld_col = 0;
			end
			mirror[ld_row*MAX_SIDE + ld_col] = val;
			if (ld_col + 1 >= n) begin
				ld_col = 0;
				if (ld_row + 1 >= n) begin
					ld_row = 0;
					held_full = 1'b1;
					rd_row = 0;
					rd_col = 0;
				end else begin
					ld_row++;
				end
			end else begin
				ld_col++;
			end
			return 1'b0;
		end
		if (!held_full) begin
			res.not_ready = 1'b1;
			return 1'b1;
		end
		if (rd_row >= n || rd_col >= n) begin
			rd_row = 0;
			rd_col = 0;
		end
		// out(r,c) = in(N-1-c, r)
		res.value = mirror[(n - 1 - rd_col)*MAX_SIDE + rd_row];
		res.last = (rd_row + 1 >= n) && (rd_col + 1 >= n);
		if (rd_col + 1 >= n) begin
			rd_col = 0;
			rd_row = (rd_row + 1 >= n) ? 0 : rd_row + 1;
		end else begin
			rd_col++;
		end
		return 1'b1;
	endfunction

	// Follow each accepted transaction and check each result against the oldest expectation
	always @(posedge clk) begin : watch
		rot_result_t predicted;
		rot_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				side_reg = cfg_wdata;
				drop_matrix();
			end
			if (start && !busy) begin
				if (rotate_step(opcode, element_value, predicted))
					due_elements.push_back(tag_typed ? tag_res : predicted);
			end
			if (done) begin
				if (due_elements.size() == 0) begin
					$error("result with nothing expected: rotated_value %h", rotated_value);
					fault_count++;
				end else begin
					want = due_elements.pop_front();
					if (rotated_value !== want.value) begin
						$error("rotated_value: expected %h, got %h", want.value, rotated_value);
						fault_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, got %b", want.last, last);
						fault_count++;
					end
					if (not_ready !== want.not_ready) begin
						$error("not_ready: expected %b, got %b", want.not_ready, not_ready);
						fault_count++;
					end
				end
			end
		end
	end

	// Present one transaction and hold it until it is taken
	task automatic drive_item(input logic op, input logic [VALUE_W-1:0] val, input bit typed,
			input rot_result_t res);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		element_value <= val;
		tag_typed <= typed;
		tag_res <= res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop start for an idle gap and scramble the payload meanwhile; a gap of zero does nothing
	task automatic idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			opcode <= 1'($urandom_range(0, 1));
			element_value <= $urandom;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [VALUE_W-1:0] next_element();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_op(input logic op);
		idle(pick_gap());
		drive_item(op, next_element(), 1'b0, '0);
	endtask

	// Let every result land, then write the side length
	task automatic set_side(input logic [SIDE_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (due_elements.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill and read back matrices of side n; unless whole is set, a few rounds are cut short on purpose
	task automatic exercise_matrix(input int n, input int rounds, input bit whole);
		int area;
		int count;
		area = n * n;
		repeat (rounds) begin
			if (whole || $urandom_range(0, 9) < 8) begin
				for (int i = 0; i < area; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_op(OP_FETCH);
					send_op(OP_LOAD);
				end
				count = whole ? 70 : $urandom_range(0, 2*area + 1);
			end else begin
				count = $urandom_range(0, area - 1);
				repeat (count)
					send_op(OP_LOAD);
				count = $urandom_range(0, 3);
			end
			repeat (count)
				send_op(OP_FETCH);
		end
	endtask

	initial begin
		int code;
		int goal;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		opcode = OP_LOAD;
		element_value = '0;
		tag_typed = 1'b0;
		tag_res = '0;

		plan = '{
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
			'{ROW_LOAD,  32'h7fff_ffff, 1'b0, '0},
			'{ROW_LOAD,  32'h8000_0000, 1'b0, '0},
			'{ROW_FETCH, 32'hffff_ffff, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
			'{ROW_CFG,   32'd0,         1'b0, '0},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
			'{ROW_LOAD,  32'hffff_ffff, 1'b0, '0},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
			'{ROW_LOAD,  32'h0000_0000, 1'b0, '0},
			'{ROW_FETCH, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
			'{ROW_CFG,   32'd1,         1'b0, '0},
			'{ROW_LOAD,  32'h8000_0000, 1'b0, '0},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
			'{ROW_CFG,   32'd2,         1'b0, '0},
			'{ROW_LOAD,  32'd1,         1'b0, '0},
			'{ROW_LOAD,  32'd2,         1'b0, '0},
			'{ROW_LOAD,  32'd3,         1'b0, '0},
			'{ROW_LOAD,  32'd4,         1'b0, '0},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'd3, 1'b0, 1'b0}},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'd1, 1'b0, 1'b0}},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'd4, 1'b0, 1'b0}},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'd2, 1'b1, 1'b0}},
			'{ROW_FETCH, 32'h0000_0000, 1'b0, '0},
			'{ROW_LOAD,  32'h5a5a_5a5a, 1'b0, '0},
			'{ROW_FETCH, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}}
		};

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				set_side(plan[i].data[SIDE_W-1:0]);
			end else begin
				idle(pick_gap());
				drive_item(plan[i].kind == ROW_FETCH ? OP_FETCH : OP_LOAD, plan[i].data,
					plan[i].typed, plan[i].res);
			end
		end

		goal = items_sent + RANDOM_ITEMS;

		// Largest matrix once, reached through an out-of-range side
		set_side(6'd63);
		exercise_matrix(MAX_SIDE, 1, 1'b1);

		// Reset value written back: partial fill and early fetches only
		set_side(6'd32);
		repeat (8)
			send_op(1'($urandom_range(0, 1)));

		// Mostly small sides from here on
		while (items_sent < goal) begin
			code = $urandom_range(0, 9);
			if (code == 0)
				code = 0;
			else if (code < 8)
				code = $urandom_range(1, 6);
			else
				code = $urandom_range(7, 9);
			set_side(code[SIDE_W-1:0]);
			no_idle = ($urandom_range(0, 3) == 0);
			exercise_matrix(code == 0 ? 1 : code, $urandom_range(1, 3), 1'b0);
		end

		// Drain and report
		@(negedge clk);
		start <= 1'b0;
		while (due_elements.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mrot_pkg.sv
hw/rtl/mrot_dp.sv
hw/rtl/mrot_ctrl.sv
hw/rtl/matrix_rotate_90.sv
hw/rtl/mrot_checker.sv
dv/tb_matrix_rotate_90.sv
